[sv/aes_cbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC package
// Shared types, register indexes, S-boxes and round helper functions.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

  localparam int MAX_ROUNDS_DEF = 14;
  localparam int CFG_IDX_W      = 4;

  localparam logic [7:0] XT_POLY = 8'h1B;
  localparam logic [7:0] RC_INIT = 8'h01;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KEY_SIZE     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_DECRYPT_MODE = cfg_idx_t'(1);
  localparam cfg_idx_t REG_KEY_WORD0    = cfg_idx_t'(2);
  localparam cfg_idx_t REG_KEY_WORD1    = cfg_idx_t'(3);
  localparam cfg_idx_t REG_KEY_WORD2    = cfg_idx_t'(4);
  localparam cfg_idx_t REG_KEY_WORD3    = cfg_idx_t'(5);
  localparam cfg_idx_t REG_IV_HIGH      = cfg_idx_t'(6);
  localparam cfg_idx_t REG_IV_LOW       = cfg_idx_t'(7);

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        restart_chain;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [63:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic first;
    logic last;
    logic inv;
  } round_ctrl_t;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [3:0] GM_E = 4'hE;
  localparam logic [3:0] GM_B = 4'hB;
  localparam logic [3:0] GM_D = 4'hD;
  localparam logic [3:0] GM_9 = 4'h9;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? XT_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int k = 0; k < 4; k++) begin
      if (m[k]) acc = acc ^ p;
      p = xtime(p);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  // byte n of a block sits at bits 127-8n, row n%4, column n/4
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv)
          t[127-8*(r+4*((c+r)%4)) -: 8] = SBOX_INV[s[127-8*(r+4*c) -: 8]];
        else
          t[127-8*(r+4*c) -: 8] = SBOX_FWD[s[127-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      if (inv) begin
        t[127-32*c -: 8] = gmul(a0, GM_E) ^ gmul(a1, GM_B) ^ gmul(a2, GM_D) ^ gmul(a3, GM_9);
        t[119-32*c -: 8] = gmul(a0, GM_9) ^ gmul(a1, GM_E) ^ gmul(a2, GM_B) ^ gmul(a3, GM_D);
        t[111-32*c -: 8] = gmul(a0, GM_D) ^ gmul(a1, GM_9) ^ gmul(a2, GM_E) ^ gmul(a3, GM_B);
        t[103-32*c -: 8] = gmul(a0, GM_B) ^ gmul(a1, GM_D) ^ gmul(a2, GM_9) ^ gmul(a3, GM_E);
      end else begin
        t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return t;
  endfunction

endpackage

[sv/aes_cbc_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC channel interface
// Valid/ready channel carrying one payload word of a given type.
// ----------------------------------------------------------------------------
interface aes_cbc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/aes_cbc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aes_cbc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[sv/aes_cbc_keyexp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC key expansion
// Produces one schedule word a cycle, writes each 128-bit round key to RAM.
// ----------------------------------------------------------------------------
module aes_cbc_keyexp #(
  parameter int MAX_ROUNDS = aes_cbc_pkg::MAX_ROUNDS_DEF,
  parameter int NRW        = $clog2(MAX_ROUNDS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         key_size_i,
  input  logic [NRW-1:0]     rounds_i,
  input  logic [7:0][31:0]   key_i,
  output logic               done_o,
  output logic               we_o,
  output logic [NRW-1:0]     waddr_o,
  output logic [127:0]       wdata_o
);
  import aes_cbc_pkg::*;

  localparam int IW = NRW + 2;

  logic          busy_q;
  logic          done_q;
  logic [IW-1:0] idx_q;
  logic [2:0]    mod_q;
  logic [7:0]    rc_q;
  logic [31:0]   win_q [8];
  logic [95:0]   acc_q;

  logic [3:0]    nk;
  logic [IW-1:0] last_idx;
  logic          from_key;
  logic [31:0]   prev_w, base_w, tmp_w, new_w;

  always_comb begin
    unique case (key_size_i)
      KS_128:  nk = 4'd4;
      KS_192:  nk = 4'd6;
      default: nk = 4'd8;
    endcase
    last_idx = {rounds_i, 2'b11};
    from_key = idx_q < IW'(nk);
    prev_w   = win_q[7];
    base_w   = win_q[3'(4'd8 - nk)];
    if (mod_q == 3'd0)
      tmp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_q, 24'h0};
    else if (nk == 4'd8 && mod_q == 3'd4)
      tmp_w = sub_word(prev_w);
    else
      tmp_w = prev_w;
    new_w = from_key ? key_i[3'd7 - idx_q[2:0]] : (base_w ^ tmp_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      mod_q  <= '0;
      rc_q   <= RC_INIT;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        mod_q  <= '0;
        rc_q   <= RC_INIT;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        mod_q <= (mod_q == 3'(nk - 4'd1)) ? 3'd0 : mod_q + 3'd1;
        if (!from_key && mod_q == 3'd0) rc_q <= xtime(rc_q);
        if (idx_q == last_idx) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      for (int k = 0; k < 7; k++) win_q[k] <= win_q[k+1];
      win_q[7] <= new_w;
      acc_q    <= {acc_q[63:0], new_w};
    end
  end

  assign done_o  = done_q;
  assign we_o    = busy_q && (idx_q[1:0] == 2'b11);
  assign waddr_o = idx_q[IW-1:2];
  assign wdata_o = {acc_q, new_w};
endmodule

[sv/aes_cbc_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC round
// One forward or inverse AES round, or the initial key add.
// ----------------------------------------------------------------------------
module aes_cbc_round (
  input  logic [127:0]             state_i,
  input  logic [127:0]             rk_i,
  input  aes_cbc_pkg::round_ctrl_t ctrl_i,
  output logic [127:0]             state_o
);
  import aes_cbc_pkg::*;

  logic [127:0] ss;

  always_comb begin
    ss = sub_shift(state_i, ctrl_i.inv);
    if (ctrl_i.first)
      state_o = state_i ^ rk_i;
    else if (ctrl_i.inv)
      state_o = ctrl_i.last ? (ss ^ rk_i) : mix(ss ^ rk_i, 1'b1);
    else
      state_o = (ctrl_i.last ? ss : mix(ss, 1'b0)) ^ rk_i;
  end
endmodule

[sv/aes_cbc_block_cipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC block cipher unit
// AES-128/192/256 in CBC mode, encrypt or decrypt, round keys held in RAM.
// ----------------------------------------------------------------------------
// Rounds run one per cycle (Nr = 10, 12, 14), bounded by the single round-key RAM
//   read port. A new word is taken only when idle, after the last result is in
//   the output register.
// After a key or key-size write the next word first runs the key schedule,
//   one schedule word per cycle.
// Reset: control, configuration and chaining value clear; the data, block and
//   output registers and round-key RAM are not; RAM is always filled before read.
module aes_cbc_block_cipher_unit #(
  parameter int MAX_ROUNDS = aes_cbc_pkg::MAX_ROUNDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aes_cbc_chan_if.sink   in_i,
  aes_cbc_chan_if.source out_o,
  aes_cbc_chan_if.sink   cfg_i
);
  import aes_cbc_pkg::*;

  localparam int DEPTH = MAX_ROUNDS + 1;
  localparam int NRW   = $clog2(DEPTH);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // configuration registers
  logic [1:0]        key_size_q;
  logic              decrypt_q;
  logic [3:0][63:0]  key_q;
  logic [127:0]      iv_q;
  logic              keys_ready_q;

  // datapath
  logic [2:0]     state_q;
  logic [127:0]   chain_q;
  logic [127:0]   data_q;
  logic [127:0]   blk_q;
  logic [NRW-1:0] step_q;
  logic           out_valid_q;
  out_word_t      out_q;

  logic           in_acc, cfg_acc, out_acc;
  logic [1:0]     ks_eff;
  logic [3:0]     nr_full;
  logic [NRW-1:0] nr;
  logic [NRW-1:0] rd_step, raddr;
  logic [127:0]   rk;
  logic [127:0]   round_out;
  logic [127:0]   result;
  round_ctrl_t    rctl;

  logic           ke_start, ke_done, ke_we;
  logic [NRW-1:0] ke_waddr;
  logic [127:0]   ke_wdata;

  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;   // writes must only come while idle; the block does not enforce this

  // key size 3 behaves as 256-bit; round count capped at MAX_ROUNDS
  always_comb begin
    ks_eff  = (key_size_q == 2'd3) ? KS_256 : key_size_q;
    nr_full = 4'd10 + {1'b0, ks_eff, 1'b0};
    nr      = (32'(nr_full) > MAX_ROUNDS) ? NRW'(MAX_ROUNDS) : NRW'(nr_full);
  end

  // round-key fetch runs one step ahead of the round logic
  always_comb begin
    if (state_q == ST_START)   rd_step = '0;
    else if (step_q == nr)     rd_step = step_q;
    else                       rd_step = step_q + 1'b1;
    raddr = decrypt_q ? (nr - rd_step) : rd_step;
  end

  assign ke_start = in_acc && !keys_ready_q;

  aes_cbc_keyexp #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .NRW        (NRW)
  ) u_keyexp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ke_start),
    .key_size_i (ks_eff),
    .rounds_i   (nr),
    .key_i      (key_q),
    .done_o     (ke_done),
    .we_o       (ke_we),
    .waddr_o    (ke_waddr),
    .wdata_o    (ke_wdata)
  );

  aes_cbc_ram #(
    .WIDTH   (128),
    .DEPTH   (DEPTH),
    .AW      (NRW)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ke_we),
    .waddr_i (ke_waddr),
    .wdata_i (ke_wdata),
    .raddr_i (raddr),
    .rdata_o (rk)
  );

  assign rctl.first = (step_q == '0);
  assign rctl.last  = (step_q == nr);
  assign rctl.inv   = decrypt_q;

  aes_cbc_round u_round (
    .state_i (blk_q),
    .rk_i    (rk),
    .ctrl_i  (rctl),
    .state_o (round_out)
  );

  // decrypt adds the chaining value after the last round
  assign result = decrypt_q ? (blk_q ^ chain_q) : blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q   <= '0;
      decrypt_q    <= 1'b0;
      key_q        <= '0;
      iv_q         <= '0;
      keys_ready_q <= 1'b0;
      chain_q      <= '0;
      state_q      <= ST_IDLE;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_i.payload.index)
          REG_KEY_SIZE: begin
            key_size_q   <= cfg_i.payload.data[1:0];
            keys_ready_q <= 1'b0;
          end
          REG_DECRYPT_MODE: decrypt_q <= cfg_i.payload.data[0];
          REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: begin
            key_q[2'd3 - 2'(cfg_i.payload.index - REG_KEY_WORD0)] <= cfg_i.payload.data;
            keys_ready_q <= 1'b0;
          end
          REG_IV_HIGH: iv_q[127:64] <= cfg_i.payload.data;
          REG_IV_LOW:  iv_q[63:0]   <= cfg_i.payload.data;
          default: ;
        endcase
      end

      // in DONE the output register is reloaded below instead
      if (out_acc && state_q != ST_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.payload.restart_chain) chain_q <= iv_q;
            state_q <= keys_ready_q ? ST_START : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          if (ke_done) begin
            keys_ready_q <= 1'b1;
            state_q      <= ST_START;
          end
        end
        ST_START: begin
          step_q  <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == nr) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            chain_q     <= decrypt_q ? data_q : result;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) data_q <= {in_i.payload.data_high, in_i.payload.data_low};
    if (state_q == ST_START) blk_q <= decrypt_q ? data_q : (data_q ^ chain_q);
    else if (state_q == ST_RUN) blk_q <= round_out;
    if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_q.result_high <= result[127:64];
      out_q.result_low  <= result[63:0];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // rounds only run on a filled key schedule
  a_keys_before_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> keys_ready_q)
    else $error("round started without expanded keys");

  // round counter never passes the round count
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> step_q <= nr)
    else $error("round step beyond round count");

  // a finished word waits while the output register is still occupied
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !out_o.ready |=> state_q == ST_DONE)
    else $error("result overwrote pending output");

  // key schedule write never lands while a round is reading
  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_START) |-> !ke_we)
    else $error("key RAM write during cipher run");
endmodule
